@@ rtl/sketch_pair_canonical_filter_unit_defines.svh @@
// Assertion helpers shared by the filter unit modules.
// Each expects clk and rst_n in the scope where it is used.
`ifndef SKETCH_PAIR_CANONICAL_FILTER_UNIT_DEFINES_SVH
`define SKETCH_PAIR_CANONICAL_FILTER_UNIT_DEFINES_SVH

// same-cycle implication
`define SPCF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/spcf_pkg.sv @@
package spcf_pkg;

  localparam int WORD_W         = 32;
  localparam int MAX_BLOCKS     = 32;
  localparam int BLK_IDX_W      = 5;
  localparam int DIST_W         = 6;
  localparam int THR_W          = 5;
  localparam int NBLK_W         = 6;
  localparam int CFG_IDX_W      = 2;
  localparam int DEF_CHUNK_BITS = 32;
  localparam int DEF_QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HAM_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHOSEN_BLOCKS = 2'd2;

  localparam logic [THR_W-1:0]      RST_HAM_THRESHOLD = 5'd1;
  localparam logic [NBLK_W-1:0]     RST_NUM_BLOCKS    = 6'd4;
  localparam logic [MAX_BLOCKS-1:0] RST_CHOSEN_BLOCKS = 32'd7;

  typedef enum logic [1:0] {
    REASON_PASS     = 2'd0,
    REASON_BLOCK_EQ = 2'd1,
    REASON_OVER     = 2'd2,
    REASON_NEAR     = 2'd3
  } reason_t;

  // classified verdict waiting between front and back
  typedef struct packed {
    logic              blk_eq;
    logic              over;
    logic              near_prev;
    logic [DIST_W-1:0] hdist;
  } spcf_entry_t;

  // block map and threshold handed from the setup sweep to the front
  typedef struct packed {
    logic                                busy;
    logic [THR_W-1:0]                    thr;
    logic [MAX_BLOCKS-1:0]               test_en;
    logic [MAX_BLOCKS-1:0][WORD_W-1:0]   mask;
  } spcf_map_t;

  function automatic logic [DIST_W-1:0] popcount(logic [WORD_W-1:0] w);
    logic [DIST_W-1:0] c;
    c = '0;
    for (int i = 0; i < WORD_W; i++) begin
      c = c + DIST_W'(w[i]);
    end
    return c;
  endfunction

  function automatic logic [WORD_W-1:0] chunk_mask(int cb);
    logic [WORD_W-1:0] m;
    for (int i = 0; i < WORD_W; i++) begin
      m[i] = (i < cb);
    end
    return m;
  endfunction

endpackage

@@ rtl/sketch_pair_canonical_filter_unit.sv @@
// Sketch pair canonical filter.
// Input channel: push a beat carrying the same chunk of both sketches
// (in_word_a, in_word_b) and in_is_current; a beat is taken when in_push is
// high and in_full is low. Earlier chunks give no result; the current chunk
// closes the pair and gives one verdict beat (out_accept, out_reject_reason,
// out_chunk_distance), read while out_empty is low and taken with out_pop.
// Configuration: cfg_valid/cfg_ready write threshold, block count or chosen
// block mask at cfg_index; cfg_ready is always high.
// Throughput: one input beat per cycle while in_full is low. A verdict is
// written to the verdict queue, then to the output register to be popped.
// After reset and after every configuration write a block map sweep runs
// over every bit position, one bit position per cycle; in_full stays high meanwhile.
// Reset restores register defaults and clears the near flag and queues.
// If the receiver stalls, verdicts collect in the verdict queue and the
// output register; in_full rises once both are occupied.
module sketch_pair_canonical_filter_unit import spcf_pkg::*; #(
  parameter int CHUNK_BITS  = DEF_CHUNK_BITS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [WORD_W-1:0]    in_word_a,
  input  logic [WORD_W-1:0]    in_word_b,
  input  logic                 in_is_current,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic                 out_accept,
  output logic [1:0]           out_reject_reason,
  output logic [DIST_W-1:0]    out_chunk_distance,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  spcf_map_t   map;
  logic        q_full;
  logic        q_wr_en;
  spcf_entry_t q_wr_data;
  logic        q_rd_en;
  spcf_entry_t q_rd_data;
  logic        q_empty;

  spcf_map #(
    .CHUNK_BITS(CHUNK_BITS)
  ) u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .map_o     (map)
  );

  spcf_front #(
    .CHUNK_BITS(CHUNK_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .map_i         (map),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_word_a     (in_word_a),
    .in_word_b     (in_word_b),
    .in_is_current (in_is_current),
    .q_full        (q_full),
    .q_wr_en       (q_wr_en),
    .q_wr_data     (q_wr_data)
  );

  spcf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_wr_en   (q_wr_en),
    .q_wr_data (q_wr_data),
    .q_full    (q_full),
    .q_rd_en   (q_rd_en),
    .q_rd_data (q_rd_data),
    .q_empty   (q_empty)
  );

  spcf_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_rd_en            (q_rd_en),
    .q_rd_data          (q_rd_data),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_accept         (out_accept),
    .out_reject_reason  (out_reject_reason),
    .out_chunk_distance (out_chunk_distance)
  );

endmodule

@@ rtl/spcf_map.sv @@
`include "sketch_pair_canonical_filter_unit_defines.svh"

module spcf_map import spcf_pkg::*; #(
  parameter int CHUNK_BITS = DEF_CHUNK_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  output spcf_map_t            map_o
);

  // bit b sits in block floor(b*n/CHUNK_BITS); division by reciprocal
  localparam int X_W     = $clog2(WORD_W * MAX_BLOCKS);
  localparam int SHIFT   = X_W + $clog2(CHUNK_BITS);
  localparam int RECIP_W = SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << SHIFT) + CHUNK_BITS - 1) / CHUNK_BITS);
  localparam int PROD_W  = X_W + RECIP_W;

  logic [THR_W-1:0]      thr_r, thr_nxt;
  logic [NBLK_W-1:0]     nblk_r, nblk_nxt;
  logic [MAX_BLOCKS-1:0] chosen_r, chosen_nxt;
  logic                  busy_r, busy_nxt;
  logic [BLK_IDX_W-1:0]  idx_r, idx_nxt;
  logic [X_W-1:0]        x_r, x_nxt;
  logic                  seen_r, seen_nxt;
  logic [MAX_BLOCKS-1:0] test_en_r, test_en_nxt;
  logic [MAX_BLOCKS-1:0][WORD_W-1:0] mask_r, mask_nxt;

  logic [NBLK_W-1:0]    n_eff;
  logic [BLK_IDX_W-1:0] sweep_blk;
  logic [PROD_W-1:0]    prod;
  logic [BLK_IDX_W-1:0] col_blk;
  logic                 bit_in_chunk;
  logic                 chosen_here;
  logic                 cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    n_eff = nblk_r;
    if (nblk_r == '0) begin
      n_eff = NBLK_W'(1);
    end else if (nblk_r > NBLK_W'(MAX_BLOCKS)) begin
      n_eff = NBLK_W'(MAX_BLOCKS);
    end
    sweep_blk    = ~idx_r;  // chosen bits scanned from the top down
    prod         = PROD_W'(x_r) * PROD_W'(RECIP);
    col_blk      = prod[SHIFT +: BLK_IDX_W];
    bit_in_chunk = 32'(idx_r) < CHUNK_BITS;
    chosen_here  = chosen_r[sweep_blk] && ({1'b0, sweep_blk} < n_eff);
  end

  always_comb begin
    thr_nxt     = thr_r;
    nblk_nxt    = nblk_r;
    chosen_nxt  = chosen_r;
    busy_nxt    = busy_r;
    idx_nxt     = idx_r;
    x_nxt       = x_r;
    seen_nxt    = seen_r;
    test_en_nxt = test_en_r;
    mask_nxt    = mask_r;
    if (cfg_wr) begin
      unique case (cfg_index)
        CFG_HAM_THRESHOLD: thr_nxt    = cfg_data[THR_W-1:0];
        CFG_NUM_BLOCKS:    nblk_nxt   = cfg_data[NBLK_W-1:0];
        CFG_CHOSEN_BLOCKS: chosen_nxt = cfg_data[MAX_BLOCKS-1:0];
        default: ;
      endcase
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      x_nxt    = '0;
      seen_nxt = 1'b0;
    end else if (busy_r) begin
      // one mask column and one test enable per cycle
      for (int j = 0; j < MAX_BLOCKS; j++) begin
        mask_nxt[j][idx_r] = bit_in_chunk && (col_blk == BLK_IDX_W'(j));
      end
      test_en_nxt[sweep_blk] = !chosen_here && seen_r;
      seen_nxt = seen_r || chosen_here;
      x_nxt    = x_r + X_W'(n_eff);
      idx_nxt  = idx_r + 1'b1;
      if (idx_r == BLK_IDX_W'(MAX_BLOCKS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= RST_HAM_THRESHOLD;
      nblk_r   <= RST_NUM_BLOCKS;
      chosen_r <= RST_CHOSEN_BLOCKS;
      busy_r   <= 1'b1;
      idx_r    <= '0;
      x_r      <= '0;
      seen_r   <= 1'b0;
    end else begin
      thr_r    <= thr_nxt;
      nblk_r   <= nblk_nxt;
      chosen_r <= chosen_nxt;
      busy_r   <= busy_nxt;
      idx_r    <= idx_nxt;
      x_r      <= x_nxt;
      seen_r   <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    test_en_r <= test_en_nxt;
    mask_r    <= mask_nxt;
  end

  assign map_o.busy    = busy_r;
  assign map_o.thr     = thr_r;
  assign map_o.test_en = test_en_r;
  assign map_o.mask    = mask_r;

  `SPCF_ASSERT_NEXT(a_cfg_restarts_sweep, cfg_wr, busy_r && (idx_r == '0) && (x_r == '0),
    "config write did not restart block map sweep")

endmodule

@@ rtl/spcf_front.sv @@
module spcf_front import spcf_pkg::*; #(
  parameter int CHUNK_BITS = DEF_CHUNK_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  spcf_map_t         map_i,
  input  logic              in_push,
  output logic              in_full,
  input  logic [WORD_W-1:0] in_word_a,
  input  logic [WORD_W-1:0] in_word_b,
  input  logic              in_is_current,
  input  logic              q_full,
  output logic              q_wr_en,
  output spcf_entry_t       q_wr_data
);

  localparam logic [WORD_W-1:0] CHUNK_MASK = chunk_mask(CHUNK_BITS);

  logic                  near_r, near_nxt;
  logic                  take;
  logic [WORD_W-1:0]     diff;
  logic [DIST_W-1:0]     hdist;
  logic                  near;
  logic [MAX_BLOCKS-1:0] zero_vec;
  logic                  blk_eq;

  assign in_full = map_i.busy || q_full;
  assign take    = in_push && !in_full;

  always_comb begin
    diff  = (in_word_a ^ in_word_b) & CHUNK_MASK;
    hdist = popcount(diff);
    near  = hdist <= {1'b0, map_i.thr};
    for (int j = 0; j < MAX_BLOCKS; j++) begin
      zero_vec[j] = ~|(diff & map_i.mask[j]);
    end
    blk_eq = |(zero_vec & map_i.test_en);
  end

  always_comb begin
    near_nxt = near_r;
    if (take) begin
      if (in_is_current) begin
        near_nxt = 1'b0;
      end else if (near) begin
        near_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= 1'b0;
    end else begin
      near_r <= near_nxt;
    end
  end

  assign q_wr_en             = take && in_is_current;
  assign q_wr_data.blk_eq    = blk_eq;
  assign q_wr_data.over      = !near;
  assign q_wr_data.near_prev = near_r;
  assign q_wr_data.hdist     = hdist;

endmodule

@@ rtl/spcf_queue.sv @@
`include "sketch_pair_canonical_filter_unit_defines.svh"

module spcf_queue import spcf_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_wr_en,
  input  spcf_entry_t q_wr_data,
  output logic        q_full,
  input  logic        q_rd_en,
  output spcf_entry_t q_rd_data,
  output logic        q_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  spcf_entry_t        slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign q_full    = count_r == CNT_W'(DEPTH);
  assign q_empty   = count_r == '0;
  assign q_rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({q_wr_en, q_rd_en})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr_en) begin
      slot_r[wr_ptr_r] <= q_wr_data;
    end
  end

  `SPCF_ASSERT_SAME(a_no_overflow, q_wr_en, !q_full,
    "verdict queue written while full")
  `SPCF_ASSERT_SAME(a_no_underflow, q_rd_en, !q_empty,
    "verdict queue read while empty")
  `SPCF_ASSERT_NEXT(a_count_up, q_wr_en && !q_rd_en, count_r == $past(count_r) + 1'b1,
    "verdict queue count did not follow a lone write")

endmodule

@@ rtl/spcf_back.sv @@
`include "sketch_pair_canonical_filter_unit_defines.svh"

module spcf_back import spcf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  output logic              q_rd_en,
  input  spcf_entry_t       q_rd_data,
  output logic              out_empty,
  input  logic              out_pop,
  output logic              out_accept,
  output logic [1:0]        out_reject_reason,
  output logic [DIST_W-1:0] out_chunk_distance
);

  logic              valid_r, valid_nxt;
  logic              accept_r;
  logic [1:0]        reason_r;
  logic [DIST_W-1:0] dist_r;
  reason_t           reason;
  logic              load;

  assign load    = !q_empty && (!valid_r || out_pop);
  assign q_rd_en = load;

  // first failing test wins
  always_comb begin
    if (q_rd_data.blk_eq) begin
      reason = REASON_BLOCK_EQ;
    end else if (q_rd_data.over) begin
      reason = REASON_OVER;
    end else if (q_rd_data.near_prev) begin
      reason = REASON_NEAR;
    end else begin
      reason = REASON_PASS;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      accept_r <= reason == REASON_PASS;
      reason_r <= reason;
      dist_r   <= q_rd_data.hdist;
    end
  end

  assign out_empty          = !valid_r;
  assign out_accept         = accept_r;
  assign out_reject_reason  = reason_r;
  assign out_chunk_distance = dist_r;

  `SPCF_ASSERT_NEXT(a_fill_output, !q_empty && !valid_r, valid_r,
    "output register not filled from waiting verdict")

endmodule

@@ dv/sketch_pair_canonical_filter_unit_test.sv @@
module sketch_pair_canonical_filter_unit_test;
  import spcf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHUNK        = DEF_CHUNK_BITS;
  localparam int ITEMS        = 1900;
  localparam int DRAIN_CYCLES = 4;
  localparam int STALL_LIMIT  = 4000;

  // index 3 decodes to no register
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic {ROW_CHUNK, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic              accept;
    reason_t           reason;
    logic [DIST_W-1:0] hdist;
  } verdict_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [WORD_W-1:0]     a;     // cfg data on ROW_CFG rows
    logic [WORD_W-1:0]     b;
    logic                  cur;
    logic                  typed;
    verdict_t              want;
  } step_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_push;
  logic                 in_full;
  logic [WORD_W-1:0]    in_word_a;
  logic [WORD_W-1:0]    in_word_b;
  logic                 in_is_current;
  logic                 out_empty;
  logic                 out_pop;
  logic                 out_accept;
  logic [1:0]           out_reject_reason;
  logic [DIST_W-1:0]    out_chunk_distance;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  sketch_pair_canonical_filter_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_word_a          (in_word_a),
    .in_word_b          (in_word_b),
    .in_is_current      (in_is_current),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_accept         (out_accept),
    .out_reject_reason  (out_reject_reason),
    .out_chunk_distance (out_chunk_distance),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // filter model state
  logic [THR_W-1:0]      thr_r;
  logic [NBLK_W-1:0]     nblk_r;
  logic [MAX_BLOCKS-1:0] chosen_r;
  logic                  near_r;

  verdict_t verdicts_due[$];
  int       errors      = 0;
  int       stall_count = 0;
  int       items_sent  = 0;
  int       thr_hint    = 1;
  int       pop_hold    = 0;
  bit       steady      = 1'b0;

  // typed verdict riding along with the beat on in_*
  logic     pin_typed;
  verdict_t pin_verdict;

  step_t plan [0:29];

  // returns 1 when the chunk closes a pair and yields a verdict
  function automatic logic judge_chunk(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
                                       input logic cur, output verdict_t v);
    logic [WORD_W-1:0] diff;
    int                d, n, top, lo, hi;
    logic              blk_eq, differs;
    reason_t           r;
    diff = '0;
    for (int k = 0; k < CHUNK && k < WORD_W; k++) diff[k] = a[k] ^ b[k];
    d = 0;
    for (int k = 0; k < WORD_W; k++) d += diff[k];
    v = '0;
    if (!cur) begin
      if (d <= int'(thr_r)) near_r = 1'b1;
      return 1'b0;
    end
    n = int'(nblk_r);
    if (n < 1) n = 1;
    if (n > MAX_BLOCKS) n = MAX_BLOCKS;
    top = 0;
    for (int j = 1; j <= n; j++) if (chosen_r[j-1]) top = j;
    blk_eq = 1'b0;
    for (int j = 1; j < top; j++) begin
      if (!chosen_r[j-1]) begin
        lo = (CHUNK * (j - 1) + n - 1) / n;
        hi = (CHUNK * j + n - 1) / n;
        differs = 1'b0;
        // an empty block has nothing that differs, so it counts as equal
        for (int k = lo; k < hi && k < WORD_W; k++) differs |= diff[k];
        if (!differs) blk_eq = 1'b1;
      end
    end
    if (blk_eq) r = REASON_BLOCK_EQ;
    else if (d > int'(thr_r)) r = REASON_OVER;
    else if (near_r) r = REASON_NEAR;
    else r = REASON_PASS;
    near_r = 1'b0;
    v.accept = (r == REASON_PASS);
    v.reason = r;
    v.hdist  = DIST_W'(d);
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    verdict_t got, want, calc;
    logic     moved;
    if (!rst_n) begin
      thr_r    = RST_HAM_THRESHOLD;
      nblk_r   = RST_NUM_BLOCKS;
      chosen_r = RST_CHOSEN_BLOCKS;
      near_r   = 1'b0;
    end else begin
      moved = 1'b0;
      got.accept = out_accept;
      got.reason = reason_t'(out_reject_reason);
      got.hdist  = out_chunk_distance;
      if (out_pop && !out_empty) begin
        moved = 1'b1;
        if (verdicts_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected verdict: accept %0d reason %0d distance %0d",
                     got.accept, got.reason, got.hdist);
        end else begin
          want = verdicts_due.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("verdict mismatch: expected accept %0d reason %0d distance %0d,",
                       want.accept, want.reason, want.hdist);
              $display("  got accept %0d reason %0d distance %0d",
                       got.accept, got.reason, got.hdist);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          CFG_HAM_THRESHOLD: thr_r    = cfg_data[THR_W-1:0];
          CFG_NUM_BLOCKS:    nblk_r   = cfg_data[NBLK_W-1:0];
          CFG_CHOSEN_BLOCKS: chosen_r = cfg_data[MAX_BLOCKS-1:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        moved = 1'b1;
        if (judge_chunk(in_word_a, in_word_b, in_is_current, calc))
          verdicts_due = {verdicts_due, (pin_typed ? pin_verdict : calc)};
      end
      stall_count = moved ? 0 : stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // receiver: stall bursts, about 6 in a hundred
  always @(posedge clk) begin
    if (steady) begin
      out_pop <= 1'b1;
    end else if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      out_pop  <= 1'b0;
    end else if ($urandom_range(99) < 6) begin
      pop_hold <= $urandom_range(0, 2);
      out_pop  <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  task automatic send_chunk(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
                            input logic cur, input logic typed, input verdict_t tv);
    cfg_valid <= 1'b0;
    if (!steady && $urandom_range(99) < 6) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_push       <= 1'b1;
    in_word_a     <= a;
    in_word_b     <= b;
    in_is_current <= cur;
    pin_typed     <= typed;
    pin_verdict   <= tv;
    do @(posedge clk); while (in_full);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    in_push   <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // hold off until every verdict is out, then let the pipe settle
  task automatic wait_drained();
    in_push   <= 1'b0;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (verdicts_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] partner(input logic [WORD_W-1:0] a);
    logic [WORD_W-1:0] b, m;
    int                lo, hi, k;
    case ($urandom_range(0, 9))
      0, 1: b = $urandom();
      2, 3, 4, 5: begin
        b = a;
        repeat ($urandom_range(0, thr_hint + 2)) begin
          k = $urandom_range(0, WORD_W - 1);
          b[k] = ~b[k];
        end
      end
      6, 7, 8: begin
        // leave a span identical so a block can compare equal
        lo = $urandom_range(0, WORD_W - 1);
        hi = $urandom_range(lo, WORD_W - 1);
        m  = '0;
        for (int i = lo; i <= hi; i++) m[i] = 1'b1;
        b = a ^ ($urandom() & ~m);
      end
      default: b = a;
    endcase
    return b;
  endfunction

  task automatic send_pair();
    int                lead;
    logic [WORD_W-1:0] a;
    lead = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 5) : $urandom_range(0, 1);
    for (int i = 0; i < lead; i++) begin
      a = $urandom();
      send_chunk(a, partner(a), 1'b0, 1'b0, '0);
    end
    a = $urandom();
    send_chunk(a, partner(a), 1'b1, 1'b0, '0);
  endtask

  task automatic retune();
    logic [WORD_W-1:0] data;
    int                pick;
    wait_drained();
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 5))
        0: pick = 0;
        1: pick = 31;
        2: pick = 1;
        default: pick = $urandom_range(0, 31);
      endcase
      data = $urandom();
      data[THR_W-1:0] = pick[THR_W-1:0];
      thr_hint = pick;
      write_reg(CFG_HAM_THRESHOLD, data);
    end
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 7))
        0: pick = 0;
        1: pick = 1;
        2: pick = 32;
        3: pick = $urandom_range(33, 63);
        default: pick = $urandom_range(2, 31);
      endcase
      data = $urandom();
      data[NBLK_W-1:0] = pick[NBLK_W-1:0];
      write_reg(CFG_NUM_BLOCKS, data);
    end
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 6))
        0: data = '0;
        1: data = '1;
        2: data = 32'd1 << $urandom_range(0, 31);
        3: data = $urandom_range(0, 15);
        default: data = $urandom();
      endcase
      write_reg(CFG_CHOSEN_BLOCKS, data);
    end
    if ($urandom_range(0, 9) == 0) write_reg(CFG_SPARE, $urandom());
  endtask

  initial begin
    int phase;
    plan = '{
      '{ROW_CHUNK, CFG_HAM_THRESHOLD, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1,
        '{1'b1, REASON_PASS, 6'd0}},
      '{ROW_CHUNK, CFG_HAM_THRESHOLD, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1,
        '{1'b0, REASON_OVER, 6'd32}},
      '{ROW_CHUNK, CFG_HAM_THRESHOLD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
      '{ROW_CHUNK, CFG_HAM_THRESHOLD, 32'h1234_5678, 32'h1234_5679, 1'b1, 1'b1,
        '{1'b0, REASON_NEAR, 6'd1}},
      '{ROW_CHUNK, CFG_HAM_THRESHOLD, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
      '{ROW_CHUNK, CFG_HAM_THRESHOLD, 32'h0000_0000, 32'h0000_0001, 1'b1, 1'b1,
        '{1'b1, REASON_PASS, 6'd1}},
      '{ROW_CFG,   CFG_CHOSEN_BLOCKS, 32'h0000_0004, '0, 1'b0, 1'b0, '0},
      '{ROW_CHUNK, CFG_HAM_THRESHOLD, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1,
        '{1'b0, REASON_BLOCK_EQ, 6'd0}},
      '{ROW_CHUNK, CFG_HAM_THRESHOLD, 32'h0000_0000, 32'h0000_0101, 1'b1, 1'b1,
        '{1'b0, REASON_OVER, 6'd2}},
      '{ROW_CFG,   CFG_HAM_THRESHOLD, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0},
      '{ROW_CHUNK, CFG_HAM_THRESHOLD, 32'h0000_0000, 32'h0000_0101, 1'b1, 1'b1,
        '{1'b1, REASON_PASS, 6'd2}},
      '{ROW_CHUNK, CFG_HAM_THRESHOLD, 32'h0000_0000, 32'hFFFF_FF00, 1'b1, 1'b1,
        '{1'b0, REASON_BLOCK_EQ, 6'd24}},
      '{ROW_CFG,   CFG_HAM_THRESHOLD, 32'hFFFF_FFE0, '0, 1'b0, 1'b0, '0},
      '{ROW_CFG,   CFG_NUM_BLOCKS,    32'h0000_0000, '0, 1'b0, 1'b0, '0},
      '{ROW_CHUNK, CFG_HAM_THRESHOLD, 32'h0000_0005, 32'h0000_0005, 1'b1, 1'b1,
        '{1'b1, REASON_PASS, 6'd0}},
      '{ROW_CFG,   CFG_NUM_BLOCKS,    32'h0000_0020, '0, 1'b0, 1'b0, '0},
      '{ROW_CFG,   CFG_CHOSEN_BLOCKS, 32'h8000_0000, '0, 1'b0, 1'b0, '0},
      '{ROW_CHUNK, CFG_HAM_THRESHOLD, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1,
        '{1'b0, REASON_OVER, 6'd31}},
      '{ROW_CHUNK, CFG_HAM_THRESHOLD, 32'h0000_0000, 32'h7FFF_FFFE, 1'b1, 1'b1,
        '{1'b0, REASON_BLOCK_EQ, 6'd30}},
      '{ROW_CFG,   CFG_NUM_BLOCKS,    32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0},
      '{ROW_CHUNK, CFG_HAM_THRESHOLD, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1, 1'b0, '0},
      '{ROW_CHUNK, CFG_HAM_THRESHOLD, 32'h0F0F_0F0F, 32'h0F0F_0F0E, 1'b1, 1'b0, '0},
      '{ROW_CFG,   CFG_CHOSEN_BLOCKS, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0},
      '{ROW_CFG,   CFG_SPARE,         32'hDEAD_BEEF, '0, 1'b0, 1'b0, '0},
      '{ROW_CHUNK, CFG_HAM_THRESHOLD, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 1'b0, '0},
      '{ROW_CHUNK, CFG_HAM_THRESHOLD, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '0},
      '{ROW_CHUNK, CFG_HAM_THRESHOLD, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1,
        '{1'b0, REASON_NEAR, 6'd0}},
      '{ROW_CHUNK, CFG_HAM_THRESHOLD, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1,
        '{1'b1, REASON_PASS, 6'd0}},
      '{ROW_CFG,   CFG_NUM_BLOCKS,    32'h0000_0001, '0, 1'b0, 1'b0, '0},
      '{ROW_CHUNK, CFG_HAM_THRESHOLD, 32'h3C3C_3C3C, 32'h3C3C_3C3C, 1'b1, 1'b0, '0}
    };

    rst_n         = 1'b0;
    in_push       = 1'b0;
    in_word_a     = '0;
    in_word_b     = '0;
    in_is_current = 1'b0;
    out_pop       = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_HAM_THRESHOLD;
    cfg_data      = '0;
    pin_typed     = 1'b0;
    pin_verdict   = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(plan[i].idx, plan[i].a);
      end else begin
        send_chunk(plan[i].a, plan[i].b, plan[i].cur, plan[i].typed, plan[i].want);
      end
    end
    thr_hint = 0;

    phase = 0;
    while (items_sent < ITEMS) begin
      retune();
      steady = (phase == 3);
      repeat ($urandom_range(15, 50)) send_pair();
      phase++;
    end
    steady = 1'b0;

    wait_drained();
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
